@@ hw/rtl/adaptive_setpoint_lowpass_2d_assert.svh @@
// Assertion macros shared by the setpoint low-pass filter RTL.
`ifndef ADAPTIVE_SETPOINT_LOWPASS_2D_ASSERT_SVH
`define ADAPTIVE_SETPOINT_LOWPASS_2D_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASLP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASLP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hw/rtl/aslp_pkg.sv @@
// Package: types and constants of the setpoint low-pass filter.
`timescale 1ns / 1ps
package aslp_pkg;

  localparam int unsigned POS_W       = 21;
  localparam int unsigned CFG_DATA_W  = 20;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned SQRT_STEPS  = 22;
  localparam int unsigned DT_W        = 17;
  localparam logic [16:0] DT_MIN_US   = 17'd1000;
  localparam logic [16:0] DT_MAX_US   = 17'd100000;

  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NEAR_DIST = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FAR_DIST  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NEAR_TAU  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FAR_TAU   = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQ_X, ST_SQ_Y, ST_SQRT, ST_DECIDE, ST_TAU1, ST_TAU2,
    ST_TAU3, ST_TAU4, ST_DIV_INIT, ST_DIV, ST_UPD_X, ST_UPD_Y, ST_FIN
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_SQ_X, OP_SQ_Y, OP_SQRT, OP_DECIDE, OP_TAU1, OP_TAU2,
    OP_TAU3, OP_TAU4, OP_DIV_INIT, OP_DIV, OP_UPD_X, OP_UPD_Y, OP_LOAD_OUT
  } op_t;

  typedef struct packed {
    logic accept;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic sqrt_last;
    logic div_last;
    logic bypass;
    logic out_free;
  } sts_t;

endpackage

@@ hw/rtl/aslp_in_if.sv @@
// Interface: input channel carrying one setpoint item per beat.
`timescale 1ns / 1ps
interface aslp_in_if;
  logic                     valid;
  logic                     ready;
  logic                     enable;
  logic signed [20:0]       target_x;
  logic signed [20:0]       target_y;
  logic signed [20:0]       pose_x;
  logic signed [20:0]       pose_y;
  logic        [31:0]       time_us;

  modport source (output valid, enable, target_x, target_y, pose_x, pose_y, time_us,
                  input ready);
  modport sink   (input valid, enable, target_x, target_y, pose_x, pose_y, time_us,
                  output ready);
endinterface

@@ hw/rtl/aslp_out_if.sv @@
// Interface: result channel carrying one command per beat.
`timescale 1ns / 1ps
interface aslp_out_if;
  logic               valid;
  logic               ready;
  logic signed [20:0] setp_x;
  logic signed [20:0] setp_y;
  logic               filtering;

  modport source (output valid, setp_x, setp_y, filtering, input ready);
  modport sink   (input valid, setp_x, setp_y, filtering, output ready);
endinterface

@@ hw/rtl/aslp_ctrl.sv @@
// Controller: sequences the datapath through one item.
`timescale 1ns / 1ps
module aslp_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  aslp_pkg::sts_t sts,
  output aslp_pkg::cmd_t cmd
);

  aslp_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= aslp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      aslp_pkg::ST_IDLE:     if (sts.in_valid) state_nxt = aslp_pkg::ST_SQ_X;
      aslp_pkg::ST_SQ_X:     state_nxt = aslp_pkg::ST_SQ_Y;
      aslp_pkg::ST_SQ_Y:     state_nxt = aslp_pkg::ST_SQRT;
      aslp_pkg::ST_SQRT:     if (sts.sqrt_last) state_nxt = aslp_pkg::ST_DECIDE;
      aslp_pkg::ST_DECIDE:   state_nxt = aslp_pkg::ST_TAU1;
      aslp_pkg::ST_TAU1:     state_nxt = sts.bypass ? aslp_pkg::ST_FIN : aslp_pkg::ST_TAU2;
      aslp_pkg::ST_TAU2:     state_nxt = aslp_pkg::ST_TAU3;
      aslp_pkg::ST_TAU3:     state_nxt = aslp_pkg::ST_TAU4;
      aslp_pkg::ST_TAU4:     state_nxt = aslp_pkg::ST_DIV_INIT;
      aslp_pkg::ST_DIV_INIT: state_nxt = aslp_pkg::ST_DIV;
      aslp_pkg::ST_DIV:      if (sts.div_last) state_nxt = aslp_pkg::ST_UPD_X;
      aslp_pkg::ST_UPD_X:    state_nxt = aslp_pkg::ST_UPD_Y;
      aslp_pkg::ST_UPD_Y:    state_nxt = aslp_pkg::ST_FIN;
      aslp_pkg::ST_FIN:      if (sts.out_free) state_nxt = aslp_pkg::ST_IDLE;
      default:               state_nxt = aslp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.accept = 1'b0;
    cmd.op     = aslp_pkg::OP_NONE;
    unique case (state_r)
      aslp_pkg::ST_IDLE:     cmd.accept = 1'b1;
      aslp_pkg::ST_SQ_X:     cmd.op = aslp_pkg::OP_SQ_X;
      aslp_pkg::ST_SQ_Y:     cmd.op = aslp_pkg::OP_SQ_Y;
      aslp_pkg::ST_SQRT:     cmd.op = aslp_pkg::OP_SQRT;
      aslp_pkg::ST_DECIDE:   cmd.op = aslp_pkg::OP_DECIDE;
      aslp_pkg::ST_TAU1:     cmd.op = sts.bypass ? aslp_pkg::OP_NONE : aslp_pkg::OP_TAU1;
      aslp_pkg::ST_TAU2:     cmd.op = aslp_pkg::OP_TAU2;
      aslp_pkg::ST_TAU3:     cmd.op = aslp_pkg::OP_TAU3;
      aslp_pkg::ST_TAU4:     cmd.op = aslp_pkg::OP_TAU4;
      aslp_pkg::ST_DIV_INIT: cmd.op = aslp_pkg::OP_DIV_INIT;
      aslp_pkg::ST_DIV:      cmd.op = aslp_pkg::OP_DIV;
      aslp_pkg::ST_UPD_X:    cmd.op = aslp_pkg::OP_UPD_X;
      aslp_pkg::ST_UPD_Y:    cmd.op = aslp_pkg::OP_UPD_Y;
      aslp_pkg::ST_FIN:      cmd.op = sts.out_free ? aslp_pkg::OP_LOAD_OUT : aslp_pkg::OP_NONE;
      default:               cmd.op = aslp_pkg::OP_NONE;
    endcase
  end

endmodule

@@ hw/rtl/aslp_datapath.sv @@
// Datapath: registers, square root, tau arithmetic, divider and filter update.
`timescale 1ns / 1ps
`include "adaptive_setpoint_lowpass_2d_assert.svh"
module aslp_datapath #(
  parameter int unsigned ALPHA_FRAC_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [aslp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [aslp_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  aslp_in_if.sink                               in_ch,
  aslp_out_if.source                            out_ch,
  input  aslp_pkg::cmd_t                        cmd,
  output aslp_pkg::sts_t                        sts
);

  localparam int unsigned F      = ALPHA_FRAC_BITS;
  localparam int unsigned STEPS  = (F > aslp_pkg::SQRT_STEPS) ? F : aslp_pkg::SQRT_STEPS;
  localparam int unsigned CNT_W  = $clog2(STEPS);

  // Configuration registers
  logic [19:0] deadband_r, near_d_r, far_d_r;
  logic [15:0] near_tau_r, far_tau_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadband_r <= 20'd180;
      near_d_r   <= 20'd180;
      far_d_r    <= 20'd1600;
      near_tau_r <= 16'd0;
      far_tau_r  <= 16'd2000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        aslp_pkg::CFG_DEADBAND:  deadband_r <= cfg_wdata;
        aslp_pkg::CFG_NEAR_DIST: near_d_r   <= cfg_wdata;
        aslp_pkg::CFG_FAR_DIST:  far_d_r    <= cfg_wdata;
        aslp_pkg::CFG_NEAR_TAU:  near_tau_r <= cfg_wdata[15:0];
        aslp_pkg::CFG_FAR_TAU:   far_tau_r  <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // Captured item and working registers
  logic               en_r;
  logic signed [20:0] tx_r, ty_r, px_r, py_r;
  logic        [31:0] now_r;
  logic        [42:0] sqx_r;
  logic        [43:0] rad_r;
  logic        [23:0] srem_r;
  logic        [21:0] root_r;
  logic   [CNT_W-1:0] cnt_r;
  logic               byp_r, flat_r, zero_r;
  logic        [16:0] dt_r;
  logic        [19:0] den_r, doff_r;
  logic        [15:0] tausel_r;
  logic        [35:0] m1_r, s_r;
  logic        [45:0] taun_r;
  logic        [36:0] dtden_r;
  logic        [46:0] dvs_r;
  logic        [47:0] drem_r;
  logic       [F-1:0] q_r;
  // Filter state
  logic               active_r;
  logic signed [20:0] sx_r, sy_r;
  logic        [31:0] last_r;
  // Output register
  logic               out_valid_r, filt_r;
  logic signed [20:0] cx_r, cy_r;

  logic signed [21:0] dx, dy;
  logic signed [43:0] dxsq, dysq;
  logic        [23:0] rem_sh, trial;
  logic        [31:0] elapsed;
  logic        [16:0] dt_c;
  logic        [19:0] fd_eff, dcl;
  logic               flat_c;
  logic signed [16:0] dtau;
  logic signed [37:0] m2, s_sum;
  logic        [47:0] rem2;
  logic               ge;
  logic signed [20:0] upd_s, upd_t;
  logic signed [21:0] upd_diff;
  logic signed [F+22:0] upd_prod, upd_step;
  logic               in_fire;

  assign in_fire = in_ch.valid && in_ch.ready;

  assign dx   = 22'(px_r) - 22'(tx_r);
  assign dy   = 22'(py_r) - 22'(ty_r);
  assign dxsq = dx * dx;
  assign dysq = dy * dy;

  assign rem_sh = {srem_r[21:0], rad_r[43:42]};
  assign trial  = {root_r, 2'b01};

  always_comb begin
    elapsed = active_r ? (now_r - last_r) : 32'd0;
    if (elapsed < 32'(aslp_pkg::DT_MIN_US))      dt_c = aslp_pkg::DT_MIN_US;
    else if (elapsed > 32'(aslp_pkg::DT_MAX_US)) dt_c = aslp_pkg::DT_MAX_US;
    else                                         dt_c = elapsed[16:0];
    fd_eff = (far_d_r < near_d_r) ? near_d_r : far_d_r;
    flat_c = (fd_eff == near_d_r);
    if (root_r < {2'b00, near_d_r})    dcl = near_d_r;
    else if (root_r > {2'b00, fd_eff}) dcl = fd_eff;
    else                               dcl = root_r[19:0];
  end

  assign dtau  = 17'(far_tau_r) - 17'(near_tau_r);
  assign m2    = $signed({1'b0, doff_r}) * dtau;
  assign s_sum = $signed({2'b00, m1_r}) + m2;

  assign rem2 = {drem_r[46:0], 1'b0};
  assign ge   = (rem2 >= {1'b0, dvs_r});

  assign upd_s    = (cmd.op == aslp_pkg::OP_UPD_Y) ? sy_r : sx_r;
  assign upd_t    = (cmd.op == aslp_pkg::OP_UPD_Y) ? ty_r : tx_r;
  assign upd_diff = 22'(upd_t) - 22'(upd_s);
  assign upd_prod = upd_diff * $signed({1'b0, q_r});
  assign upd_step = upd_prod >>> F;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      en_r  <= in_ch.enable;
      tx_r  <= in_ch.target_x;
      ty_r  <= in_ch.target_y;
      px_r  <= in_ch.pose_x;
      py_r  <= in_ch.pose_y;
      now_r <= in_ch.time_us;
    end
    case (cmd.op)
      aslp_pkg::OP_SQ_X: sqx_r <= dxsq[42:0];
      aslp_pkg::OP_SQ_Y: begin
        rad_r  <= {1'b0, sqx_r} + {1'b0, dysq[42:0]};
        srem_r <= '0;
        root_r <= '0;
        cnt_r  <= '0;
      end
      aslp_pkg::OP_SQRT: begin
        rad_r <= {rad_r[41:0], 2'b00};
        cnt_r <= cnt_r + 1'b1;
        if (rem_sh >= trial) begin
          srem_r <= rem_sh - trial;
          root_r <= {root_r[20:0], 1'b1};
        end else begin
          srem_r <= rem_sh;
          root_r <= {root_r[20:0], 1'b0};
        end
      end
      aslp_pkg::OP_DECIDE: begin
        dt_r     <= dt_c;
        flat_r   <= flat_c;
        den_r    <= flat_c ? 20'd1 : (fd_eff - near_d_r);
        doff_r   <= dcl - near_d_r;
        tausel_r <= (root_r >= {2'b00, fd_eff}) ? far_tau_r : near_tau_r;
      end
      aslp_pkg::OP_TAU1: m1_r <= flat_r ? {20'd0, tausel_r} : (36'(near_tau_r) * 36'(den_r));
      aslp_pkg::OP_TAU2: s_r <= s_sum[35:0];
      aslp_pkg::OP_TAU3: taun_r <= 46'(s_r) * 46'd1000;
      aslp_pkg::OP_TAU4: dtden_r <= 37'(dt_r) * 37'(den_r);
      aslp_pkg::OP_DIV_INIT: begin
        dvs_r  <= {1'b0, taun_r} + {10'd0, dtden_r};
        drem_r <= {11'd0, dtden_r};
        zero_r <= (taun_r == '0);
        q_r    <= '0;
        cnt_r  <= '0;
      end
      aslp_pkg::OP_DIV: begin
        drem_r <= ge ? (rem2 - {1'b0, dvs_r}) : rem2;
        q_r    <= {q_r[F-2:0], ge};
        cnt_r  <= cnt_r + 1'b1;
      end
      default: ;
    endcase
  end

  // Filter state and bypass decision
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      sx_r     <= '0;
      sy_r     <= '0;
      last_r   <= '0;
      byp_r    <= 1'b0;
    end else begin
      case (cmd.op)
        aslp_pkg::OP_DECIDE: begin
          if (!en_r || (root_r < {2'b00, deadband_r})) begin
            byp_r    <= 1'b1;
            active_r <= 1'b0;
          end else begin
            byp_r    <= 1'b0;
            active_r <= 1'b1;
            last_r   <= now_r;
            if (!active_r) begin
              sx_r <= px_r;
              sy_r <= py_r;
            end
          end
        end
        aslp_pkg::OP_UPD_X: sx_r <= zero_r ? tx_r : (sx_r + upd_step[20:0]);
        aslp_pkg::OP_UPD_Y: sy_r <= zero_r ? ty_r : (sy_r + upd_step[20:0]);
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == aslp_pkg::OP_LOAD_OUT) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == aslp_pkg::OP_LOAD_OUT) begin
      cx_r   <= byp_r ? tx_r : sx_r;
      cy_r   <= byp_r ? ty_r : sy_r;
      filt_r <= !byp_r;
    end
  end

  assign in_ch.ready      = cmd.accept;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.setp_x    = cx_r;
  assign out_ch.setp_y    = cy_r;
  assign out_ch.filtering = filt_r;

  assign sts.in_valid  = in_ch.valid;
  assign sts.sqrt_last = (cnt_r == CNT_W'(aslp_pkg::SQRT_STEPS - 1));
  assign sts.div_last  = (cnt_r == CNT_W'(F - 1));
  assign sts.bypass    = byp_r;
  assign sts.out_free  = !out_valid_r || out_ch.ready;

  `ASLP_ASSERT_NEXT(a_load_sets_valid, cmd.op == aslp_pkg::OP_LOAD_OUT, out_valid_r)
  `ASLP_ASSERT_NOW(a_load_no_overwrite, cmd.op == aslp_pkg::OP_LOAD_OUT, !out_valid_r || out_ch.ready)
  `ASLP_ASSERT_NEXT(a_decide_active, cmd.op == aslp_pkg::OP_DECIDE, active_r == !byp_r)

endmodule

@@ hw/rtl/adaptive_setpoint_lowpass_2d.sv @@
// Top level: adaptive 2-D setpoint low-pass filter, controller plus datapath.
`timescale 1ns / 1ps
//
// Channel   Direction  Beat contents
// in_ch     sink       enable, target_x/y, pose_x/y, time_us
// out_ch    source     setp_x/y, filtering
// cfg_*     write      cfg_index selects register, cfg_wdata carries value
//
// An item takes an accept state, the squaring of x and y, 22 square-root steps
// and a decision; a bypassed item then goes on to the output register.
// A filtered item adds 4 tau steps, 1 + ALPHA_FRAC_BITS divider steps and the
// update of x and then of y. The square root is serial, the divider restoring.
// Reset is synchronous and active low; it restores the register defaults
// and clears the filter state. A stalled result waits in the output register
// while the next item is already accepted and worked on.
module adaptive_setpoint_lowpass_2d #(
  parameter int unsigned ALPHA_FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [aslp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [aslp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  aslp_in_if.sink                           in_ch,
  aslp_out_if.source                        out_ch
);

  // Commands from the controller, status back from the datapath.
  aslp_pkg::cmd_t cmd;
  aslp_pkg::sts_t sts;

  aslp_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  // The datapath holds the registers, the filter state and the output stage.
  aslp_datapath #(
    .ALPHA_FRAC_BITS (ALPHA_FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
